>>> hdl/fld_pkg.sv
// shared constants, types and helpers for the fixed-length packet deframer
`timescale 1ns / 1ps

package fld_pkg;

  // default payload store depth per bank
  localparam int PAYLOAD_MAX_DEF = 16;

  // packet descriptors in flight between front and back, one store bank each
  localparam int QUEUE_DEPTH = 2;

  // field widths
  localparam int BYTE_W     = 8;
  localparam int LEN_W      = 5;
  localparam int INDEX_W    = 4;
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  // register reset values
  localparam logic [BYTE_W-1:0] HEADER_FIRST_RST  = 8'd255;
  localparam logic [BYTE_W-1:0] HEADER_SECOND_RST = 8'd254;
  localparam logic [BYTE_W-1:0] TAIL_BYTE_RST     = 8'd253;
  localparam logic [LEN_W-1:0]  PAYLOAD_LEN_RST   = 5'd4;

  // register map, word index
  typedef enum logic [1:0] {
    REG_HEADER_FIRST   = 2'd0,
    REG_HEADER_SECOND  = 2'd1,
    REG_TAIL_BYTE      = 2'd2,
    REG_PAYLOAD_LENGTH = 2'd3
  } reg_idx_e;

  // front framing states
  typedef enum logic [3:0] {
    F_IDLE = 4'b0001,
    F_HDR2 = 4'b0010,
    F_FILL = 4'b0100,
    F_TAIL = 4'b1000
  } front_state_e;

  // back emitter states
  typedef enum logic [1:0] {
    B_IDLE = 2'b01,
    B_SHOW = 2'b10
  } back_state_e;

  // clamp the programmed length into 1 .. max
  function automatic logic [7:0] eff_len(input logic [LEN_W-1:0] len,
                                         input logic [7:0] max);
    logic [7:0] len_ext;
    len_ext = {3'b000, len};
    if (len == '0) begin
      return 8'd1;
    end else if (len_ext > max) begin
      return max;
    end else begin
      return len_ext;
    end
  endfunction

endpackage

>>> hdl/fld_front.sv
// front part: framing state machine, payload capture and packet descriptor push
`timescale 1ns / 1ps

module fld_front import fld_pkg::*; #(
  parameter int PAYLOAD_MAX = PAYLOAD_MAX_DEF,
  localparam int CNT_W = $clog2(PAYLOAD_MAX + 1),
  localparam int AW    = (PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [BYTE_W-1:0] rx_byte_i,
  input  logic [BYTE_W-1:0] header_first_i,
  input  logic [BYTE_W-1:0] header_second_i,
  input  logic [BYTE_W-1:0] tail_byte_i,
  input  logic [LEN_W-1:0]  payload_length_i,
  output logic              mem_we_o,
  output logic [AW:0]       mem_waddr_o,
  output logic [BYTE_W-1:0] mem_wdata_o,
  output logic              desc_push_o,
  output logic [CNT_W:0]    desc_o
);

  front_state_e     state_q, state_d;
  logic [CNT_W-1:0] fill_q, fill_d;
  logic             bank_q, bank_d;
  logic [CNT_W-1:0] eff;

  assign eff = CNT_W'(eff_len(payload_length_i, 8'(PAYLOAD_MAX)));

  // classify each accepted byte against the current framing state
  always_comb begin
    state_d  = state_q;
    fill_d   = fill_q;
    bank_d   = bank_q;
    mem_we_o = 1'b0;
    desc_push_o = 1'b0;
    if (accept_i) begin
      unique case (state_q)
        F_IDLE: begin
          if (rx_byte_i == header_first_i) state_d = F_HDR2;
        end
        F_HDR2: begin
          if (rx_byte_i == header_second_i) state_d = F_FILL;
        end
        F_FILL: begin
          if (fill_q < CNT_W'(PAYLOAD_MAX)) begin
            mem_we_o = 1'b1;
            fill_d   = fill_q + CNT_W'(1);
          end
          if (fill_d >= eff) state_d = F_TAIL;
        end
        F_TAIL: begin
          if (rx_byte_i == tail_byte_i) begin
            desc_push_o = 1'b1;
            fill_d      = '0;
            bank_d      = ~bank_q;
            state_d     = F_IDLE;
          end
        end
        default: state_d = F_IDLE;
      endcase
    end
  end

  // payload write into the current bank, descriptor names bank and count
  assign mem_waddr_o = {bank_q, fill_q[AW-1:0]};
  assign mem_wdata_o = rx_byte_i;
  assign desc_o      = {bank_q, fill_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      fill_q  <= '0;
      bank_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      bank_q  <= bank_d;
    end
  end

endmodule

>>> hdl/fld_queue.sv
// two-entry descriptor queue between front and back
`timescale 1ns / 1ps

module fld_queue import fld_pkg::*; #(
  parameter int W = 1
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  input  logic         pop_i,
  output logic         valid_o,
  output logic         full_o,
  output logic [W-1:0] data_o
);

  logic [W-1:0] mem_q [QUEUE_DEPTH];
  logic         wr_ptr_q, rd_ptr_q;
  logic [1:0]   cnt_q;
  logic         do_push, do_pop;

  assign valid_o = (cnt_q != 2'd0);
  assign full_o  = (cnt_q == 2'(QUEUE_DEPTH));
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= data_i;
  end

  // pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= ~wr_ptr_q;
      if (do_pop)  rd_ptr_q <= ~rd_ptr_q;
      if (do_push && !do_pop)      cnt_q <= cnt_q + 2'd1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 2'd1;
    end
  end

endmodule

>>> hdl/fld_back.sv
// back part: banked payload store and in-order emitter of completed packets
`timescale 1ns / 1ps

module fld_back import fld_pkg::*; #(
  parameter int PAYLOAD_MAX = PAYLOAD_MAX_DEF,
  localparam int CNT_W = $clog2(PAYLOAD_MAX + 1),
  localparam int AW    = (PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX) : 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               mem_we_i,
  input  logic [AW:0]        mem_waddr_i,
  input  logic [BYTE_W-1:0]  mem_wdata_i,
  input  logic               desc_valid_i,
  input  logic [CNT_W:0]     desc_i,
  output logic               desc_pop_o,
  input  logic               pop,
  output logic               empty,
  output logic [BYTE_W-1:0]  payload_byte_o,
  output logic [INDEX_W-1:0] payload_index_o,
  output logic               last_byte_o
);

  logic [BYTE_W-1:0] mem [2**(AW+1)];
  logic [BYTE_W-1:0] rd_data_q;
  logic              rd_en;
  logic [AW:0]       rd_addr;

  back_state_e       state_q, state_d;
  logic [CNT_W-1:0]  idx_q, idx_d;
  logic [CNT_W:0]    idx_inc;
  logic [CNT_W-1:0]  len;
  logic              bank;
  logic              last;
  logic [CNT_W+INDEX_W-1:0] idx_ext;

  assign bank    = desc_i[CNT_W];
  assign len     = desc_i[CNT_W-1:0];
  assign idx_inc = {1'b0, idx_q} + {{CNT_W{1'b0}}, 1'b1};
  assign last    = (idx_inc == {1'b0, len});

  // store: one write port from the front, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we_i) mem[mem_waddr_i] <= mem_wdata_i;
    if (rd_en)    rd_data_q <= mem[rd_addr];
  end

  // walk the head packet one byte per transaction
  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    rd_en      = 1'b0;
    desc_pop_o = 1'b0;
    unique case (state_q)
      B_IDLE: begin
        if (desc_valid_i) begin
          rd_en   = 1'b1;
          state_d = B_SHOW;
        end
      end
      B_SHOW: begin
        if (pop) begin
          if (last) begin
            desc_pop_o = 1'b1;
            idx_d      = '0;
            state_d    = B_IDLE;
          end else begin
            idx_d = idx_inc[CNT_W-1:0];
            rd_en = 1'b1;
          end
        end
      end
      default: state_d = B_IDLE;
    endcase
    rd_addr = {bank, idx_d[AW-1:0]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  // result ports
  assign idx_ext         = {{INDEX_W{1'b0}}, idx_q};
  assign empty           = (state_q != B_SHOW);
  assign payload_byte_o  = rd_data_q;
  assign payload_index_o = idx_ext[INDEX_W-1:0];
  assign last_byte_o     = last;

endmodule

>>> hdl/fixed_length_packet_deframer.sv
// top level: configuration registers and the front, queue and back parts
//
// channel   direction  handshake            payload
// rx        in         push / full          rx_byte_i
// result    out        empty / pop          payload_byte_o, payload_index_o, last_byte_o
// config    in         psel/penable/pwrite  paddr, pwdata, prdata (word per register)
//
// the front state machine takes a new received byte on every push while full is low
// a tail byte releases a packet; the back emits one payload byte per cycle
// within a packet while pop is held, read through a registered store read port
// full rises while two packets wait in the descriptor queue (one per store bank)
// reset clears the framing state, queue and emitter; the store itself is not cleared
`timescale 1ns / 1ps

module fixed_length_packet_deframer import fld_pkg::*; #(
  parameter int PAYLOAD_MAX = PAYLOAD_MAX_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // received bytes
  input  logic                  push,
  output logic                  full,
  input  logic [BYTE_W-1:0]     rx_byte_i,
  // payload results
  output logic                  empty,
  input  logic                  pop,
  output logic [BYTE_W-1:0]     payload_byte_o,
  output logic [INDEX_W-1:0]    payload_index_o,
  output logic                  last_byte_o,
  // configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int CNT_W = $clog2(PAYLOAD_MAX + 1);
  localparam int AW    = (PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX) : 1;

  logic [BYTE_W-1:0] header_first_q, header_second_q, tail_byte_q;
  logic [LEN_W-1:0]  payload_length_q;
  logic              cfg_wr;
  reg_idx_e          reg_sel;

  logic              accept;
  logic              mem_we;
  logic [AW:0]       mem_waddr;
  logic [BYTE_W-1:0] mem_wdata;
  logic              desc_push, desc_pop, desc_valid;
  logic [CNT_W:0]    desc_in, desc_out;

  // configuration port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_sel = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_first_q   <= HEADER_FIRST_RST;
      header_second_q  <= HEADER_SECOND_RST;
      tail_byte_q      <= TAIL_BYTE_RST;
      payload_length_q <= PAYLOAD_LEN_RST;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_HEADER_FIRST:   header_first_q   <= pwdata[BYTE_W-1:0];
        REG_HEADER_SECOND:  header_second_q  <= pwdata[BYTE_W-1:0];
        REG_TAIL_BYTE:      tail_byte_q      <= pwdata[BYTE_W-1:0];
        REG_PAYLOAD_LENGTH: payload_length_q <= pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (reg_sel)
      REG_HEADER_FIRST:   prdata = APB_DATA_W'(header_first_q);
      REG_HEADER_SECOND:  prdata = APB_DATA_W'(header_second_q);
      REG_TAIL_BYTE:      prdata = APB_DATA_W'(tail_byte_q);
      REG_PAYLOAD_LENGTH: prdata = APB_DATA_W'(payload_length_q);
      default:            prdata = '0;
    endcase
  end

  // input transaction
  assign accept = push && !full;

  fld_front #(.PAYLOAD_MAX(PAYLOAD_MAX)) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .accept_i         (accept),
    .rx_byte_i        (rx_byte_i),
    .header_first_i   (header_first_q),
    .header_second_i  (header_second_q),
    .tail_byte_i      (tail_byte_q),
    .payload_length_i (payload_length_q),
    .mem_we_o         (mem_we),
    .mem_waddr_o      (mem_waddr),
    .mem_wdata_o      (mem_wdata),
    .desc_push_o      (desc_push),
    .desc_o           (desc_in)
  );

  fld_queue #(.W(CNT_W + 1)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (desc_push),
    .data_i  (desc_in),
    .pop_i   (desc_pop),
    .valid_o (desc_valid),
    .full_o  (full),
    .data_o  (desc_out)
  );

  fld_back #(.PAYLOAD_MAX(PAYLOAD_MAX)) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .mem_we_i        (mem_we),
    .mem_waddr_i     (mem_waddr),
    .mem_wdata_i     (mem_wdata),
    .desc_valid_i    (desc_valid),
    .desc_i          (desc_out),
    .desc_pop_o      (desc_pop),
    .pop             (pop),
    .empty           (empty),
    .payload_byte_o  (payload_byte_o),
    .payload_index_o (payload_index_o),
    .last_byte_o     (last_byte_o)
  );

endmodule

>>> hdl/fld_checker.sv
// port-level checker for the deframer result channel, bound to the top level
`timescale 1ns / 1ps

module fld_checker import fld_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               empty,
  input logic               pop,
  input logic [BYTE_W-1:0]  payload_byte_o,
  input logic [INDEX_W-1:0] payload_index_o,
  input logic               last_byte_o
);

  // a waiting result holds until taken
  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(payload_byte_o) &&
      $stable(payload_index_o) && $stable(last_byte_o)))
    else $error("result changed while waiting");

  // within a packet the next byte follows at once with the next index
  a_index_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop && !last_byte_o) |=>
      (!empty && payload_index_o == INDEX_W'($past(payload_index_o) + 4'd1)))
    else $error("payload index did not advance by one");

  // a packet shown after an empty spell starts at index zero
  a_packet_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty |=> (empty || payload_index_o == '0))
    else $error("packet did not start at index zero");

endmodule

bind fixed_length_packet_deframer fld_checker u_fld_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .empty           (empty),
  .pop             (pop),
  .payload_byte_o  (payload_byte_o),
  .payload_index_o (payload_index_o),
  .last_byte_o     (last_byte_o)
);
